// ===== hw/rtl/id_bitmap_allocator_with_hash_bucket_defines.svh =====
// ----------------------------------------------------------------------------
// Identifier allocator: assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ID_BITMAP_ALLOCATOR_WITH_HASH_BUCKET_DEFINES_SVH
`define ID_BITMAP_ALLOCATOR_WITH_HASH_BUCKET_DEFINES_SVH

// checked outside reset only
`define IBAH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define IBAH_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ibah_pkg.sv =====
// ----------------------------------------------------------------------------
// ibah_pkg
// Widths, hash constants and request codes of the identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ibah_pkg;

  localparam int ID_W          = 10;   // identifier field width
  localparam int KEY_W         = 16;   // identifier as hashed: two bytes
  localparam int NUM_BUCKET    = 128;  // power of two
  localparam int BKT_W         = $clog2(NUM_BUCKET);
  localparam int DEF_MAX_IDS   = 1024;
  localparam int DEF_WORD_BITS = 64;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_t;

  // One FNV-1a round kept modulo the bucket count: the low bits of a
  // product depend only on the low bits of its operands.
  function automatic logic [BKT_W-1:0] fnv_step(input logic [BKT_W-1:0] h,
                                                input logic [7:0]       b);
    logic [2*BKT_W-1:0] p;
    p = (2*BKT_W)'(h ^ BKT_W'(b)) * (2*BKT_W)'(FNV_PRIME[BKT_W-1:0]);
    return p[BKT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ibah_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// ibah_bitmap_ram
// Bitmap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ibah_bitmap_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ibah_hash.sv =====
// ----------------------------------------------------------------------------
// ibah_hash
// Two-stage FNV-1a bucket hash over an identifier, low byte first.
// ----------------------------------------------------------------------------
`default_nettype none

module ibah_hash (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ibah_pkg::KEY_W-1:0]  key,
  output logic      [ibah_pkg::BKT_W-1:0]  bucket
);

  import ibah_pkg::*;

  logic             s1_vld_r;
  logic [BKT_W-1:0] h1_r;
  logic [7:0]       hi_r;
  logic [BKT_W-1:0] bkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h1_r <= fnv_step(FNV_BASIS[BKT_W-1:0], key[7:0]);
      hi_r <= key[15:8];
    end
    if (s1_vld_r) begin
      bkt_r <= fnv_step(h1_r, hi_r);
    end
  end

  assign bucket = bkt_r;

endmodule

`default_nettype wire

// ===== hw/rtl/id_bitmap_allocator_with_hash_bucket.sv =====
// ----------------------------------------------------------------------------
// id_bitmap_allocator_with_hash_bucket
// Bitmap identifier allocator with FNV-1a bucket number per grant/release.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_req_type, in_release_id
//   out_     out  out_valid/out_ready  out_ok, out_granted_id, out_bucket
//
// A request steps through accept and word read, modify and write back,
// hash second round and result load. Per-word full flags pick the word, so
// one word read and at most one write-back serve a request. A full bitmap
// skips to the result.
// After reset a clearing pass writes all MAX_IDS/WORD_BITS words (16 by default)
// of the RAM; in_ready stays low meanwhile.
// A stalled result holds in the output register; the next request is taken
// while it waits and parks in the load step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module id_bitmap_allocator_with_hash_bucket #(
  parameter int MAX_IDS   = ibah_pkg::DEF_MAX_IDS,   // multiple of WORD_BITS
  parameter int WORD_BITS = ibah_pkg::DEF_WORD_BITS  // power of two
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_req_type,
  input  wire logic [ibah_pkg::ID_W-1:0]  in_release_id,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_ok,
  output logic      [ibah_pkg::ID_W-1:0]  out_granted_id,
  output logic      [ibah_pkg::BKT_W-1:0] out_bucket
);

  import ibah_pkg::*;

  localparam int NWORDS = MAX_IDS / WORD_BITS;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int WADDR  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_MOD,
    ST_HASH,
    ST_OUT
  } state_t;

  state_t               state_r;
  logic [WADDR-1:0]     clr_addr_r;
  logic [NWORDS-1:0]    full_r;
  req_t                 req_r;
  logic [KEY_W-1:0]     key_r;
  logic [WADDR-1:0]     word_r;
  logic                 in_range_r;
  logic                 ok_r;
  logic                 out_valid_r;
  logic                 out_ok_r;
  logic [ID_W-1:0]      out_id_r;
  logic [BKT_W-1:0]     out_bkt_r;

  logic [NWORDS-1:0]    alloc_oh;
  logic [WADDR-1:0]     alloc_word;
  logic                 all_full;
  logic [KEY_W-1:0]     in_key;
  logic [KEY_W-1:0]     in_word_full;
  logic                 in_range;
  logic                 in_alloc;
  logic [WADDR-1:0]     raddr;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] zero_oh;
  logic [BIT_W-1:0]     bit_idx;
  logic [WORD_BITS-1:0] mod_word;
  logic [KEY_W-1:0]     mod_key;
  logic                 we;
  logic [WADDR-1:0]     waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [BKT_W-1:0]     hash_bucket;
  logic                 out_load;

  // lowest word that still has a free bit
  assign alloc_oh = ~full_r & (full_r + NWORDS'(1));
  assign all_full = &full_r;

  always_comb begin
    alloc_word = '0;
    for (int i = 0; i < NWORDS; i++) begin
      if (alloc_oh[i]) begin
        alloc_word = alloc_word | WADDR'(i);
      end
    end
  end

  assign in_key       = KEY_W'(in_release_id);
  assign in_word_full = in_key >> BIT_W;
  assign in_range     = (in_word_full < KEY_W'(NWORDS));
  assign in_alloc     = (req_t'(in_req_type) == REQ_ALLOC);
  assign raddr        = in_alloc ? alloc_word : in_word_full[WADDR-1:0];

  // lowest clear bit of the word just read
  assign zero_oh = ~rdata & (rdata + WORD_BITS'(1));

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (zero_oh[i]) begin
        bit_idx = bit_idx | BIT_W'(i);
      end
    end
  end

  always_comb begin
    if (req_r == REQ_RELEASE) begin
      mod_word = rdata & ~(WORD_BITS'(1) << key_r[BIT_W-1:0]);
      mod_key  = key_r;
    end else begin
      mod_word = rdata | zero_oh;
      mod_key  = (KEY_W'(word_r) << BIT_W) | KEY_W'(bit_idx);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = word_r;
    wdata = mod_word;
    if (state_r == ST_CLR) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = (clr_addr_r == '0) ? WORD_BITS'(1) : '0;  // identifier 0 reserved
    end else if (state_r == ST_MOD) begin
      we = (req_r == REQ_ALLOC) || in_range_r;
    end
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  ibah_bitmap_ram #(
    .DEPTH (NWORDS),
    .WIDTH (WORD_BITS),
    .AW    (WADDR)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ibah_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_MOD),
    .key    (mod_key),
    .bucket (hash_bucket)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          clr_addr_r <= clr_addr_r + WADDR'(1);
          if (clr_addr_r == WADDR'(NWORDS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_r      <= req_t'(in_req_type);
            key_r      <= (in_alloc && all_full) ? '0 : in_key;
            in_range_r <= in_range;
            word_r     <= raddr;
            if (in_alloc && all_full) begin
              ok_r    <= 1'b0;
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (req_r == REQ_ALLOC) begin
            full_r[word_r] <= (mod_word == FULL_WORD);
          end else if (in_range_r) begin
            full_r[word_r] <= 1'b0;
          end
          key_r   <= mod_key;
          ok_r    <= 1'b1;
          state_r <= ST_HASH;
        end
        ST_HASH: begin
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_ok_r    <= ok_r;
            out_id_r    <= key_r[ID_W-1:0];
            out_bkt_r   <= ok_r ? hash_bucket : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLR;
        end
      endcase
    end
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_granted_id = out_id_r;
  assign out_bucket     = out_bkt_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ibah_checker.sv =====
// ----------------------------------------------------------------------------
// ibah_checker
// Port-level checks on the identifier allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "id_bitmap_allocator_with_hash_bucket_defines.svh"

module ibah_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_ok,
  input wire logic [ibah_pkg::ID_W-1:0]  out_granted_id,
  input wire logic [ibah_pkg::BKT_W-1:0] out_bucket
);

  // one request in flight at a time
  `IBAH_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready, "word taken while busy")

  // a failed allocate carries no identifier and no bucket
  `IBAH_ASSERT(a_fail_zero, (out_valid && !out_ok) |-> (out_granted_id == '0 && out_bucket == '0), "failed word not zeroed")

  `IBAH_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_granted_id) && $stable(out_bucket)), "stalled result word changed")

  // clearing pass follows reset: nothing taken or shown
  `IBAH_ASSERT_RST(a_reset_quiet, !rst_n |=> (!in_ready && !out_valid), "active straight after reset")

endmodule

bind id_bitmap_allocator_with_hash_bucket ibah_checker u_ibah_checker (.*);

`default_nettype wire
